FILE: rtl/fec_pkg.sv
package fec_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Configuration register indexes
  localparam logic REG_HEAP_LOW  = 1'b0;
  localparam logic REG_HEAP_HIGH = 1'b1;

  // Operation broadcast to every cell of the extent row
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_PROBE  = 3'd1,  // latch start < addr
    OP_GROW   = 3'd2,  // predecessor absorbs the freed block
    OP_INSERT = 3'd3,  // open a slot at the insert point, shift right
    OP_TEST   = 3'd4,  // focus cell checks contiguity with its right neighbor
    OP_ABSORB = 3'd5   // focus cell eats its right neighbor, shift left
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] addr;
    logic [31:0] rsize;
  } cell_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic        vld;
    logic        lt;
    logic [31:0] start;
    logic [31:0] len;
  } cell_view_t;

  // Per-cell flags seen by the sequencer
  typedef struct packed {
    logic pred;
    logic succ;
    logic focus;
    logic match;
  } cell_stat_t;

endpackage

FILE: rtl/fec_rem.sv
module fec_rem
  import fec_pkg::*;
#(
  parameter int GRANULE_BYTES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 go,
  input  logic [31:0]                          val,
  output logic                                 done,
  output logic [$clog2(GRANULE_BYTES+1)-1:0]   rem
);

  // rem < G fits the port width
  localparam int RW = $clog2(GRANULE_BYTES + 1);
  // floor(val / G) == (val * MAGIC) >> SH for every 32-bit val,
  // with MAGIC = ceil(2^SH / G) and SH = 32 + ceil(log2 G)
  localparam int SH = 32 + $clog2(GRANULE_BYTES);
  localparam logic [32:0] MAGIC =
    33'(((64'd1 << SH) + 64'(GRANULE_BYTES - 1)) / 64'(GRANULE_BYTES));

  logic [31:0]   val_r;
  logic [48:0]   plo_r, plo_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          v1_r, v2_r, v3_r;
  logic          done_r;
  logic [48:0]   phi;
  logic [64:0]   prod;
  logic [31:0]   qg;

  // stage 1: low half product; stage 2: high half, sum, quotient;
  // stage 3: remainder = val - q * G
  always_comb begin
    plo_nxt = 49'(val_r[15:0]) * 49'(MAGIC);
    phi     = 49'(val_r[31:16]) * 49'(MAGIC);
    prod    = {16'd0, plo_r} + {phi, 16'd0};
    q_nxt   = 32'(prod >> SH);
    qg      = q_r * 32'(GRANULE_BYTES);
    rem_nxt = RW'(val_r - qg);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      val_r <= val;
    end
    if (v1_r) begin
      plo_r <= plo_nxt;
    end
    if (v2_r) begin
      q_r <= q_nxt;
    end
    if (v3_r) begin
      rem_r <= rem_nxt;
    end
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= go;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/fec_cell.sv
module fec_cell
  import fec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  cell_view_t  left,
  input  cell_view_t  right,
  output cell_view_t  view,
  output cell_stat_t  stat,
  output logic [32:0] end_sum
);

  logic [31:0] start_r, start_nxt;
  logic [31:0] len_r, len_nxt;
  logic        vld_r, vld_nxt;
  logic        lt_r, lt_nxt;
  logic        focus_r, focus_nxt;
  logic        right_r, right_nxt;   // sits right of the focus cell
  logic        match_r, match_nxt;
  logic        pred, pos;

  assign pred    = lt_r && !right.lt;
  assign pos     = !lt_r && left.lt;
  assign end_sum = {1'b0, start_r} + {1'b0, len_r};

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    vld_nxt   = vld_r;
    lt_nxt    = lt_r;
    focus_nxt = focus_r;
    right_nxt = right_r;
    match_nxt = match_r;
    case (cmd.op)
      OP_PROBE: begin
        lt_nxt = vld_r && (start_r < cmd.addr);
      end
      OP_GROW: begin
        if (pred) begin
          len_nxt = len_r + cmd.rsize;
        end
        focus_nxt = pred;
        right_nxt = !lt_r;
      end
      OP_INSERT: begin
        if (pos) begin
          start_nxt = cmd.addr;
          len_nxt   = cmd.rsize;
          vld_nxt   = 1'b1;
        end else if (!lt_r) begin
          start_nxt = left.start;
          len_nxt   = left.len;
          vld_nxt   = left.vld;
        end
        focus_nxt = pos;
        right_nxt = !lt_r && !pos;
      end
      OP_TEST: begin
        match_nxt = focus_r && right.vld && (end_sum == {1'b0, right.start});
      end
      OP_ABSORB: begin
        if (focus_r) begin
          len_nxt = len_r + right.len;
        end else if (right_r) begin
          start_nxt = right.start;
          len_nxt   = right.len;
          vld_nxt   = right.vld;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    if (!rst_n) begin
      vld_r   <= 1'b0;
      lt_r    <= 1'b0;
      focus_r <= 1'b0;
      right_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      lt_r    <= lt_nxt;
      focus_r <= focus_nxt;
      right_r <= right_nxt;
      match_r <= match_nxt;
    end
  end

  assign view.vld   = vld_r;
  assign view.lt    = lt_r;
  assign view.start = start_r;
  assign view.len   = len_r;

  assign stat.pred  = pred;
  assign stat.succ  = pos && vld_r;
  assign stat.focus = focus_r;
  assign stat.match = match_r;

endmodule

FILE: rtl/free_extent_coalescer_core.sv
// Free extent coalescer: address-sorted table of free extents.
// Input: pulse start with in_block_addr / in_block_size while busy is low;
// the word is taken at that edge; unless rejected, busy is high to the result.
// Result: out_valid is high for exactly one cycle with out_status,
// out_merged_start, out_merged_length and out_free_count. The receiver
// cannot stall; the word is gone after that cycle.
// Sequence: a rejected word (zero size, address outside heap bounds) answers
// in the cycle after acceptance. An overlap, overflow or full-table error
// answers after the granule remainder (three multiply stages plus the done
// flag), round and check; a good word goes on through check and update,
// contiguity test, successor join, output select and the result cycle.
// busy drops with out_valid, so the next word can go in the cycle the result
// shows; a new word is taken only once the last one has answered.
// The extents live in a row of MAX_EXTENTS cells; every cell compares its
// own start against the address in parallel and inserts/removals shift the
// row by one cell per cycle through neighbor links.
// Config: cfg_we/cfg_index/cfg_wdata write heap_low (0) or heap_high (1);
// write only while busy is low.
// Reset (rst_n low, synchronous): table empty, heap bounds 0 / all ones.
module free_extent_coalescer_core
  import fec_pkg::*;
#(
  parameter int MAX_EXTENTS   = 32,
  parameter int GRANULE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_block_addr,
  input  logic [31:0] in_block_size,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_merged_start,
  output logic [31:0] out_merged_length,
  output logic [5:0]  out_free_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int RW = $clog2(GRANULE_BYTES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_ROUND = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_TEST  = 7'b0010000,
    S_JOIN  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] heap_low_r, heap_high_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] addr_r, size_r;
  logic [32:0] rsize_r, rsize_nxt;
  logic [32:0] pend_r, pend_nxt;
  logic [31:0] succ_start_r, succ_start_nxt;
  logic        has_pred_r, has_succ_r;
  logic        has_succ_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_start_r, out_start_nxt;
  logic [31:0] out_len_r, out_len_nxt;
  logic [5:0]  out_count_r, out_count_nxt;

  logic          accept, bad_in;
  logic          rem_done;
  logic [RW-1:0] rem;
  logic [32:0]   bend;
  logic          err_ovl, grow, full;
  logic          any_match;
  logic [31:0]   focus_start, focus_len;

  cell_cmd_t  cmd;
  cell_view_t views [MAX_EXTENTS];
  cell_stat_t stats [MAX_EXTENTS];
  logic [32:0] ends [MAX_EXTENTS];

  assign accept = start && (state_r == S_IDLE);
  assign bad_in = (in_block_size == 32'd0) || (in_block_addr > heap_high_r) ||
                  (in_block_addr < heap_low_r);

  // ---- granule remainder, reciprocal multiply over three stages ----
  fec_rem #(.GRANULE_BYTES(GRANULE_BYTES)) u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (accept && !bad_in),
    .val  (in_block_size),
    .done (rem_done),
    .rem  (rem)
  );

  // ---- extent row ----
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    cell_view_t lv, rv;
    if (i == 0) begin : g_first
      assign lv = '{vld: 1'b1, lt: 1'b1, start: 32'd0, len: 32'd0};
    end else begin : g_mid_l
      assign lv = views[i-1];
    end
    if (i == MAX_EXTENTS - 1) begin : g_last
      assign rv = '{vld: 1'b0, lt: 1'b0, start: 32'd0, len: 32'd0};
    end else begin : g_mid_r
      assign rv = views[i+1];
    end
    fec_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .left   (lv),
      .right  (rv),
      .view   (views[i]),
      .stat   (stats[i]),
      .end_sum(ends[i])
    );
  end

  // one-hot selects over the row
  always_comb begin
    pend_nxt       = '0;
    succ_start_nxt = '0;
    has_succ_nxt   = 1'b0;
    any_match      = 1'b0;
    focus_start    = '0;
    focus_len      = '0;
    for (int k = 0; k < MAX_EXTENTS; k++) begin
      pend_nxt       = pend_nxt | (stats[k].pred ? ends[k] : 33'd0);
      succ_start_nxt = succ_start_nxt | (stats[k].succ ? views[k].start : 32'd0);
      has_succ_nxt   = has_succ_nxt | stats[k].succ;
      any_match      = any_match | stats[k].match;
      focus_start    = focus_start | (stats[k].focus ? views[k].start : 32'd0);
      focus_len      = focus_len | (stats[k].focus ? views[k].len : 32'd0);
    end
  end

  // round up to granule: add (G - rem) unless already aligned
  assign rsize_nxt = (rem == '0) ? {1'b0, size_r}
                   : {1'b0, size_r} + (33'(GRANULE_BYTES) - 33'(rem));

  // checks on the registered neighbors
  assign bend    = {1'b0, addr_r} + {1'b0, rsize_r[31:0]};
  assign err_ovl = rsize_r[32] || bend[32] ||
                   (has_pred_r && (pend_r > {1'b0, addr_r})) ||
                   (has_succ_r && (bend > {1'b0, succ_start_r}));
  assign grow    = has_pred_r && (pend_r == {1'b0, addr_r});
  assign full    = !grow && (count_r == CW'(MAX_EXTENTS));

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd.op         = OP_NONE;
    cmd.addr       = addr_r;
    cmd.rsize      = rsize_r[31:0];
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_count_nxt  = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (bad_in) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BAD;
            out_start_nxt  = '0;
            out_len_nxt    = '0;
            out_count_nxt  = 6'(count_r);
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.op = OP_PROBE;
        if (rem_done) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (err_ovl || full) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_ovl ? ST_OVERLAP : ST_FULL;
          out_start_nxt  = '0;
          out_len_nxt    = '0;
          out_count_nxt  = 6'(count_r);
          state_nxt      = S_IDLE;
        end else if (grow) begin
          cmd.op    = OP_GROW;
          state_nxt = S_TEST;
        end else begin
          cmd.op    = OP_INSERT;
          count_nxt = count_r + CW'(1);
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        cmd.op    = OP_TEST;
        state_nxt = S_JOIN;
      end
      S_JOIN: begin
        if (any_match) begin
          cmd.op    = OP_ABSORB;
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_start_nxt  = focus_start;
        out_len_nxt    = focus_len;
        out_count_nxt  = 6'(count_r);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_block_addr;
      size_r <= in_block_size;
    end
    if (state_r == S_ROUND) begin
      rsize_r      <= rsize_nxt;
      pend_r       <= pend_nxt;
      succ_start_r <= succ_start_nxt;
      has_pred_r   <= views[0].lt;
      has_succ_r   <= has_succ_nxt;
    end
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      heap_low_r  <= 32'h0000_0000;
      heap_high_r <= 32'hFFFF_FFFF;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAP_LOW:  heap_low_r  <= cfg_wdata;
          REG_HEAP_HIGH: heap_high_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_merged_start  = out_start_r;
  assign out_merged_length = out_len_r;
  assign out_free_count    = out_count_r;

endmodule
